@@ design/bpf_pkg.sv @@
// Package for the byte packet framer: frame constants, item kind codes
// and the run descriptor handed from the frame builder to the serializer.
// No dependencies.
`timescale 1ns / 1ps

package bpf_pkg;

	localparam logic [7:0] MAGIC_HI  = 8'hAB;
	localparam logic [7:0] MAGIC_LO  = 8'hCD;
	localparam logic [7:0] BYTE_MASK = 8'hFF;

	localparam int MAX_RUN = 9;
	localparam int RUN_W   = $clog2(MAX_RUN + 1);

	localparam logic KIND_START   = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	// bytes[0] goes out first
	typedef struct packed {
		logic [MAX_RUN-1:0][7:0] bytes;
		logic [RUN_W-1:0]        count;
		logic                    has_ck;
	} run_t;

	function automatic logic [31:0] ck_step(input logic [31:0] sum, input logic [7:0] b);
		ck_step = {sum[30:0], 1'b0} ^ {24'd0, b & BYTE_MASK};
	endfunction

endpackage

@@ design/bpf_item_if.sv @@
// Channel interfaces of the byte packet framer: input item channel and
// frame byte channel. No dependencies.
`timescale 1ns / 1ps

interface bpf_item_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  frame_type;
	logic [15:0] payload_length;
	logic [7:0]  payload_byte;

	modport source (output valid, kind, frame_type, payload_length, payload_byte, input ready);
	modport sink   (input valid, kind, frame_type, payload_length, payload_byte, output ready);
endinterface

interface bpf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       frame_end;
	logic       run_end;

	modport source (output valid, out_byte, frame_end, run_end, input ready);
	modport sink   (input valid, out_byte, frame_end, run_end, output ready);
endinterface

@@ design/byte_packet_framer.sv @@
// Top level of the byte packet framer: frame builder plus byte serializer.
// Depends on bpf_pkg, bpf_item_if, bpf_core and bpf_serializer.
//
//   channel  dir  payload                                            accept
//   items    in   kind, frame_type, payload_length, payload_byte     valid && ready
//   frame    out  out_byte, frame_end, run_end                       valid && ready
//
// A payload item yields one byte; the last payload item of a frame yields
// five bytes, a start item five, or nine for an empty frame.
// The output serializer emits one byte per cycle unless the frame channel stalls.
// Dropped payload items retire without output.
// Reset clears the frame state and empties both stages.
// A stalled frame channel holds the current byte; one item waits in the
// input register meanwhile.
`timescale 1ns / 1ps

module byte_packet_framer (
	input  logic       clk,
	input  logic       arst_n,
	bpf_item_if.sink   items,
	bpf_byte_if.source frame
);
	import bpf_pkg::*;

	run_t run;
	logic load;
	logic ser_free;

	bpf_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.items    (items),
		.ser_free (ser_free),
		.load     (load),
		.run      (run)
	);

	bpf_serializer u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.run      (run),
		.ser_free (ser_free),
		.frame    (frame)
	);

`ifndef SYNTH
	a_frame_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		frame.valid && frame.frame_end |-> frame.run_end)
		else $error("frame_end without run_end");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> ser_free)
		else $error("run loaded into busy serializer");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> frame.valid)
		else $error("loaded run not presented");
`endif

endmodule

@@ design/bpf_core.sv @@
// Frame builder: input register, frame state and the combinational run build.
// Depends on bpf_pkg and bpf_item_if.
`timescale 1ns / 1ps

module bpf_core (
	input  logic          clk,
	input  logic          arst_n,
	bpf_item_if.sink      items,
	input  logic          ser_free,
	output logic          load,
	output bpf_pkg::run_t run
);
	import bpf_pkg::*;

	logic        valid_s1;
	logic        kind_s1;
	logic [7:0]  type_s1;
	logic [15:0] len_s1;
	logic [7:0]  pbyte_s1;

	logic [31:0] sum_q;
	logic [15:0] remaining_q;
	logic        open_q;

	logic [31:0] sum_d;
	logic [15:0] remaining_d;
	logic        open_d;
	logic [31:0] hsum;
	logic [31:0] psum;
	logic [15:0] rem_dec;
	logic        advance;

	always_comb begin
		hsum = ck_step(ck_step(ck_step(ck_step(ck_step(32'd0, MAGIC_HI), MAGIC_LO),
			type_s1), len_s1[15:8]), len_s1[7:0]);
		psum    = ck_step(sum_q, pbyte_s1);
		rem_dec = remaining_q - 16'd1;

		run         = '0;
		sum_d       = sum_q;
		remaining_d = remaining_q;
		open_d      = open_q;

		if (kind_s1 == KIND_START) begin
			run.bytes[0] = MAGIC_HI;
			run.bytes[1] = MAGIC_LO;
			run.bytes[2] = type_s1;
			run.bytes[3] = len_s1[15:8];
			run.bytes[4] = len_s1[7:0];
			if (len_s1 == 16'd0) begin
				// empty frame: checksum right after the header
				run.bytes[5] = hsum[31:24];
				run.bytes[6] = hsum[23:16];
				run.bytes[7] = hsum[15:8];
				run.bytes[8] = hsum[7:0];
				run.count    = RUN_W'(9);
				run.has_ck   = 1'b1;
				sum_d        = '0;
				remaining_d  = '0;
				open_d       = 1'b0;
			end else begin
				run.count   = RUN_W'(5);
				sum_d       = hsum;
				remaining_d = len_s1;
				open_d      = 1'b1;
			end
		end else if (open_q) begin
			run.bytes[0] = pbyte_s1;
			if (rem_dec == 16'd0) begin
				run.bytes[1] = psum[31:24];
				run.bytes[2] = psum[23:16];
				run.bytes[3] = psum[15:8];
				run.bytes[4] = psum[7:0];
				run.count    = RUN_W'(5);
				run.has_ck   = 1'b1;
				sum_d        = '0;
				remaining_d  = '0;
				open_d       = 1'b0;
			end else begin
				run.count   = RUN_W'(1);
				sum_d       = psum;
				remaining_d = rem_dec;
			end
		end
	end

	// a dropped payload item retires even while the serializer is busy
	assign advance     = valid_s1 && (run.count == '0 || ser_free);
	assign load        = advance && run.count != '0;
	assign items.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			sum_q       <= '0;
			remaining_q <= '0;
			open_q      <= 1'b0;
		end else begin
			if (items.ready)
				valid_s1 <= items.valid;
			if (advance) begin
				sum_q       <= sum_d;
				remaining_q <= remaining_d;
				open_q      <= open_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			kind_s1  <= items.kind;
			type_s1  <= items.frame_type;
			len_s1   <= items.payload_length;
			pbyte_s1 <= items.payload_byte;
		end
	end

endmodule

@@ design/bpf_serializer.sv @@
// Run serializer: holds one run of up to nine bytes and shifts it out,
// one byte per handshake. Depends on bpf_pkg and bpf_byte_if.
`timescale 1ns / 1ps

module bpf_serializer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  bpf_pkg::run_t run,
	output logic          ser_free,
	bpf_byte_if.source    frame
);
	import bpf_pkg::*;

	logic [MAX_RUN-1:0][7:0] buf_q;
	logic [RUN_W-1:0]        count_q;
	logic                    ck_q;
	logic                    take;

	assign take            = frame.valid && frame.ready;
	assign frame.valid     = count_q != '0;
	assign frame.out_byte  = buf_q[0];
	assign frame.run_end   = count_q == RUN_W'(1);
	assign frame.frame_end = ck_q && count_q == RUN_W'(1);
	assign ser_free        = count_q == '0 || (count_q == RUN_W'(1) && frame.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ck_q    <= 1'b0;
		end else if (load) begin
			count_q <= run.count;
			ck_q    <= run.has_ck;
		end else if (take) begin
			count_q <= count_q - RUN_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			buf_q <= run.bytes;
		else if (take)
			buf_q <= {8'h00, buf_q[MAX_RUN-1:1]};
	end

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for byte_packet_framer: drives start and payload items
// and checks every frame byte against an in-bench frame predictor.
// Depends on bpf_pkg, bpf_item_if / bpf_byte_if and the framer RTL.
`timescale 1ns / 1ps

module testbench;
	import bpf_pkg::*;

	localparam int TIMEOUT_CYCLES = 200000;
	localparam int LONG_HOLD      = 200;
	localparam int SETTLE_CYCLES  = 20;

	typedef struct packed {
		logic        kind;
		logic [7:0]  frame_type;
		logic [15:0] payload_length;
		logic [7:0]  payload_byte;
		logic [1:0]  phase;
		logic        drain_first;
	} pend_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
		logic       run_end;
	} frame_byte_t;

	logic clk;
	logic arst_n;

	bpf_item_if items_ch ();
	bpf_byte_if frame_ch ();

	byte_packet_framer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items_ch),
		.frame  (frame_ch)
	);

	pend_item_t  pending_items[$];
	frame_byte_t frame_bytes_due[$];
	frame_byte_t run_bytes[$];

	// predictor state
	logic [31:0] ck_sum;
	logic [15:0] bytes_left;
	logic        in_frame;

	int   mismatch_count;
	int   cycle_count;
	logic item_taken;
	logic [1:0] cur_phase;
	int   hold_left;
	logic long_hold_done;

	// stimulus generation state
	logic [1:0] gen_phase;
	logic       gen_drain;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int idle_pct(input logic [1:0] ph, input logic sender);
		if (ph == 2'd0)
			return sender ? 17 : 73;
		else if (ph == 2'd1)
			return sender ? 73 : 17;
		return 0;
	endfunction

	task automatic add_frame_byte(input logic [7:0] b);
		frame_byte_t fb;
		fb.out_byte  = b;
		fb.frame_end = 1'b0;
		fb.run_end   = 1'b0;
		run_bytes = {run_bytes, fb};
		ck_sum = {ck_sum[30:0], 1'b0} ^ {24'd0, b};
	endtask

	task automatic add_checksum();
		frame_byte_t fb;
		for (int i = 0; i < 4; i++) begin
			fb.out_byte  = ck_sum[31 - 8*i -: 8];
			fb.frame_end = (i == 3);
			fb.run_end   = 1'b0;
			run_bytes = {run_bytes, fb};
		end
		in_frame   = 1'b0;
		bytes_left = '0;
		ck_sum     = '0;
	endtask

	task automatic frame_predict(input pend_item_t it);
		frame_byte_t fb;
		run_bytes.delete();
		if (it.kind == KIND_START) begin
			ck_sum     = '0;
			in_frame   = 1'b1;
			bytes_left = it.payload_length;
			add_frame_byte(MAGIC_HI);
			add_frame_byte(MAGIC_LO);
			add_frame_byte(it.frame_type);
			add_frame_byte(it.payload_length[15:8]);
			add_frame_byte(it.payload_length[7:0]);
			if (bytes_left == 16'd0)
				add_checksum();
		end else if (in_frame) begin
			add_frame_byte(it.payload_byte);
			bytes_left = bytes_left - 16'd1;
			if (bytes_left == 16'd0)
				add_checksum();
		end
		if (run_bytes.size() > 0) begin
			run_bytes[run_bytes.size() - 1].run_end = 1'b1;
			foreach (run_bytes[i]) begin
				fb = run_bytes[i];
				frame_bytes_due = {frame_bytes_due, fb};
			end
		end
	endtask

	task automatic add_item(input logic kind, input logic [7:0] ftype,
			input logic [15:0] plen, input logic [7:0] pbyte);
		pend_item_t it;
		it.kind           = kind;
		it.frame_type     = ftype;
		it.payload_length = plen;
		it.payload_byte   = pbyte;
		it.phase          = gen_phase;
		it.drain_first    = gen_drain;
		gen_drain = 1'b0;
		pending_items = {pending_items, it};
	endtask

	task automatic add_start(input logic [7:0] ftype, input logic [15:0] plen);
		add_item(KIND_START, ftype, plen, 8'($urandom));
	endtask

	task automatic add_payload(input logic [7:0] pbyte);
		add_item(KIND_PAYLOAD, 8'($urandom), 16'($urandom), pbyte);
	endtask

	// Mostly complete frames with random content; some cut short (abandoned
	// by the next start) and some stray payload bytes between frames.
	task automatic add_random_frames(input int target);
		int n;
		int sel;
		int plen;
		int cut;
		n = 0;
		while (n < target) begin
			sel = $urandom_range(0, 19);
			if (sel < 2) begin
				add_payload(8'($urandom));
			end else begin
				if (sel == 2) begin
					plen = $urandom_range(0, 65535);
					cut  = $urandom_range(0, 6);
					if (cut > plen)
						cut = plen;
				end else if (sel < 5) begin
					plen = $urandom_range(9, 40);
					cut  = plen;
				end else begin
					plen = $urandom_range(0, 8);
					cut  = (sel == 5) ? $urandom_range(0, plen) : plen;
				end
				add_start(8'($urandom), 16'(plen));
				n++;
				for (int i = 0; i < cut; i++) begin
					add_payload(8'($urandom));
					n++;
				end
			end
		end
	endtask

	// both sides: output checking, input acceptance and prediction
	always @(posedge clk) begin : check_frame
		pend_item_t  got_item;
		frame_byte_t want;
		if (frame_ch.valid && frame_ch.ready) begin
			if (frame_bytes_due.size() == 0) begin
				$error("unexpected frame byte: out_byte=%h frame_end=%b run_end=%b",
					frame_ch.out_byte, frame_ch.frame_end, frame_ch.run_end);
				mismatch_count++;
			end else begin
				want = frame_bytes_due.pop_front();
				if (frame_ch.out_byte !== want.out_byte) begin
					$error("out_byte: expected %h, got %h", want.out_byte, frame_ch.out_byte);
					mismatch_count++;
				end
				if (frame_ch.frame_end !== want.frame_end) begin
					$error("frame_end: expected %b, got %b", want.frame_end,
						frame_ch.frame_end);
					mismatch_count++;
				end
				if (frame_ch.run_end !== want.run_end) begin
					$error("run_end: expected %b, got %b", want.run_end, frame_ch.run_end);
					mismatch_count++;
				end
			end
		end
		// predicted after the output check: a byte leaving this edge never
		// belongs to the item entering at the same edge
		if (items_ch.valid && items_ch.ready) begin
			got_item.kind           = items_ch.kind;
			got_item.frame_type     = items_ch.frame_type;
			got_item.payload_length = items_ch.payload_length;
			got_item.payload_byte   = items_ch.payload_byte;
			got_item.phase          = 2'd0;
			got_item.drain_first    = 1'b0;
			frame_predict(got_item);
		end
		item_taken <= items_ch.valid && items_ch.ready;
	end

	always @(negedge clk) begin : drive_items
		pend_item_t nxt;
		logic       go;
		if (!arst_n) begin
			items_ch.valid <= 1'b0;
		end else if (!items_ch.valid || item_taken) begin
			go = 1'b0;
			if (pending_items.size() > 0) begin
				go = 1'b1;
				if (pending_items[0].drain_first && frame_bytes_due.size() != 0)
					go = 1'b0;
				else if ($urandom_range(99) < idle_pct(pending_items[0].phase, 1'b1))
					go = 1'b0;
			end
			if (go) begin
				nxt = pending_items.pop_front();
				items_ch.valid          <= 1'b1;
				items_ch.kind           <= nxt.kind;
				items_ch.frame_type     <= nxt.frame_type;
				items_ch.payload_length <= nxt.payload_length;
				items_ch.payload_byte   <= nxt.payload_byte;
				cur_phase               <= nxt.phase;
			end else begin
				items_ch.valid <= 1'b0;
			end
		end
	end

	// One long hold-off in the unthrottled phase, while items keep coming,
	// fills the framer and backs up the input channel.
	always @(negedge clk) begin
		if (!arst_n) begin
			frame_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			frame_ch.ready <= 1'b0;
			hold_left      <= hold_left - 1;
		end else if (cur_phase == 2'd2 && !long_hold_done && frame_bytes_due.size() > 0) begin
			frame_ch.ready <= 1'b0;
			hold_left      <= LONG_HOLD;
			long_hold_done <= 1'b1;
		end else begin
			frame_ch.ready <= ($urandom_range(99) >= idle_pct(cur_phase, 1'b0));
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= TIMEOUT_CYCLES) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin
		items_ch.valid          = 1'b0;
		items_ch.kind           = KIND_START;
		items_ch.frame_type     = '0;
		items_ch.payload_length = '0;
		items_ch.payload_byte   = '0;
		frame_ch.ready          = 1'b0;
		arst_n          = 1'b0;
		ck_sum          = '0;
		bytes_left      = '0;
		in_frame        = 1'b0;
		mismatch_count  = 0;
		cycle_count     = 0;
		item_taken      = 1'b0;
		cur_phase       = 2'd0;
		hold_left       = 0;
		long_hold_done  = 1'b0;
		gen_phase       = 2'd0;
		gen_drain       = 1'b0;

		// directed: stray payload, empty frames, short frames, abandoned frames
		add_payload(8'hFF);
		add_start(8'h00, 16'h0000);
		add_start(8'hFF, 16'h0000);
		add_start(8'h5A, 16'h0001);
		add_payload(8'h00);
		add_start(8'hA5, 16'h0002);
		add_payload(8'hFF);
		add_payload(8'h80);
		add_payload(8'h3C);
		add_start(8'hC3, 16'hFFFF);
		add_payload(8'h55);
		add_payload(8'hAA);
		add_start(8'h01, 16'h0100);
		add_start(8'h7E, 16'h0003);
		add_payload(8'h12);
		add_payload(8'h34);
		add_payload(8'h56);
		add_start(8'h80, 16'h8001);
		add_start(8'h0F, 16'h0001);
		add_payload(8'h01);

		add_random_frames(80);
		gen_phase = 2'd1;
		gen_drain = 1'b1;
		add_random_frames(80);
		gen_phase = 2'd2;
		gen_drain = 1'b1;
		add_random_frames(80);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_items.size() != 0 || items_ch.valid)
			@(posedge clk);
		while (frame_bytes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
